/* rtl/core/ectg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ectg_pkg
// shared widths, codes, stage payload types and the sine and exp2 tables
// ----------------------------------------------------------------------------
package ectg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int EXP_TABLE_BITS  = 10;
  localparam int SIN_N = 1 << SINE_TABLE_BITS;
  localparam int SIN_H = SIN_N / 2;
  localparam int SIN_Q = SIN_N / 4;
  localparam int EXP_N = 1 << EXP_TABLE_BITS;

  localparam int VAL_W      = 32;
  localparam int DUR_W      = 31;
  localparam int PER_W      = 16;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int U_W        = 17;
  localparam int SIN_W      = 18;
  localparam int EXP_W      = 17;

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint LN2_Q30 = 64'sd744261118;

  localparam longint SIN_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};
  localparam longint EXP_DIV [12] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_VALUE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OSC_PERIOD  = 3'd5;

  // curve codes
  localparam logic [MODE_W-1:0] MODE_LINEAR     = 4'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD_IN    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_QUAD_OUT   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_QUAD_INOUT = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ELAS_IN    = 4'd4;
  localparam logic [MODE_W-1:0] MODE_ELAS_OUT   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ELAS_INOUT = 4'd6;
  localparam logic [MODE_W-1:0] MODE_VIB_IN     = 4'd7;
  localparam logic [MODE_W-1:0] MODE_VIB_OUT    = 4'd8;

  typedef logic signed [SIN_W-1:0] sin_tab_t [SIN_N];
  typedef logic [EXP_W-1:0] exp_tab_t [EXP_N];

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
    logic [30:0] rem;
    logic [30:0] clamp;
  } a_t;

  typedef struct packed {
    logic [30:0]    rem;
    logic [U_W-1:0] u;
  } b_t;

  typedef struct packed {
    logic [U_W-1:0] u;
    logic [U_W-1:0] w;
    logic [U_W-1:0] n;
    logic           hi;
  } c_t;

  typedef struct packed {
    logic [U_W-1:0] u;
    logic           hi;
    logic [U_W-1:0] sq;
  } side_t;

  typedef struct packed {
    side_t          side;
    logic [U_W-1:0] n;
    logic [15:0]    rem;
    logic [15:0]    q;
  } d_t;

  typedef struct packed {
    side_t                      side;
    logic [SINE_TABLE_BITS-1:0] sidx;
    logic [EXP_TABLE_BITS-1:0]  fidx;
    logic [3:0]                 a;
  } e1_t;

  typedef struct packed {
    side_t                   side;
    logic signed [SIN_W-1:0] sinv;
    logic [EXP_W-1:0]        amp;
  } e2_t;

  typedef struct packed {
    side_t              side;
    logic signed [35:0] prod;
  } e3_t;

  function automatic longint quarter_sin(longint x);
    longint x2;
    longint term;
    longint sum;
    x2 = (x * x) / ONE_Q30;
    term = x;
    sum = x;
    for (int k = 0; k < 10; k++) begin
      term = -((term * x2) / ONE_Q30) / SIN_DIV[k];
      sum = sum + term;
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint   x;
    longint   s;
    for (int i = 0; i < SIN_N; i++) tab[i] = '0;
    for (int i = 0; i <= SIN_Q; i++) begin
      x = (64'sd2 * PI_Q30 * longint'(i)) / SIN_N;
      s = (quarter_sin(x) + 64'sd8192) >>> 14;
      tab[i] = SIN_W'(s);
      tab[SIN_H - i] = SIN_W'(s);
      tab[SIN_H + i] = SIN_W'(-s);
      if (i > 0) tab[SIN_N - i] = SIN_W'(-s);
    end
    return tab;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    longint   y;
    longint   term;
    longint   sum;
    for (int i = 0; i < EXP_N; i++) begin
      y = (LN2_Q30 * longint'(i)) / EXP_N;
      term = ONE_Q30;
      sum = ONE_Q30;
      for (int k = 0; k < 12; k++) begin
        term = ((term * y) / ONE_Q30) / EXP_DIV[k];
        sum = sum + term;
      end
      tab[i] = EXP_W'((sum + 64'sd8192) >>> 14);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/easing_curve_tween_generator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// easing_curve_tween_generator_unit
// throughput: one request per cycle while the skid stage is empty, set by the
//   restoring dividers that retire one quotient bit per pipeline stage (wrap,
//   phase and oscillation divides); reset: synchronous active-low rst_n clears
//   all valid bits and loads the register defaults; no clearing pass, the block is ready right away
// ----------------------------------------------------------------------------
module easing_curve_tween_generator_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ectg_pkg::VAL_W-1:0]      in_time_now,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ectg_pkg::VAL_W-1:0]      out_tween_value,
  output logic                                   out_done_flag,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ectg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ectg_pkg::VAL_W-1:0]             cfg_data
);
  import ectg_pkg::*;

  localparam int A_N   = 33;
  localparam int B_N   = 18;
  localparam int D_N   = 34;
  localparam int ST_C  = A_N + B_N;
  localparam int ST_D0 = ST_C + 1;
  localparam int ST_E1 = ST_D0 + D_N;
  localparam int NST   = ST_E1 + 6;

  localparam sin_tab_t SIN_TAB = build_sin_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

  logic [MODE_W-1:0]       mode_r;
  logic                    loop_en_r;
  logic [DUR_W-1:0]        duration_r;
  logic signed [VAL_W-1:0] start_r;
  logic signed [VAL_W-1:0] end_r;
  logic [PER_W-1:0]        period_r;

  logic [DUR_W-1:0] dur_eff;
  logic [PER_W-1:0] per_eff;
  logic             is_osc;
  logic             is_vib;
  logic             en;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] done_r;
  logic           done0;

  a_t  a_r   [A_N];
  a_t  a_nxt [A_N];
  b_t  b_r   [B_N];
  b_t  b_nxt [B_N];
  c_t  c_r;
  c_t  c_nxt;
  d_t  d_r   [D_N];
  d_t  d_nxt [D_N];
  e1_t e1_r;
  e1_t e1_nxt;
  e2_t e2_r;
  e2_t e2_nxt;
  e3_t e3_r;
  e3_t e3_nxt;

  logic signed [20:0]      e4_scale_r;
  logic signed [20:0]      e4_scale_nxt;
  logic signed [53:0]      f1_prod_r;
  logic signed [53:0]      f1_prod_nxt;
  logic signed [VAL_W-1:0] f2_val_r;
  logic signed [VAL_W-1:0] f2_val_nxt;

  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic                    out_done_r;
  logic                    skid_v_r;
  logic signed [VAL_W-1:0] skid_val_r;
  logic                    skid_done_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_LINEAR;
      loop_en_r  <= 1'b0;
      duration_r <= 31'd65536;
      start_r    <= 32'sd0;
      end_r      <= 32'sd65536;
      period_r   <= 16'd19661;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CURVE_MODE:  mode_r     <= cfg_data[MODE_W-1:0];
        CFG_LOOP_ENABLE: loop_en_r  <= cfg_data[0];
        CFG_DURATION:    duration_r <= cfg_data[DUR_W-1:0];
        CFG_START_VALUE: start_r    <= cfg_data;
        CFG_END_VALUE:   end_r      <= cfg_data;
        CFG_OSC_PERIOD:  period_r   <= cfg_data[PER_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign dur_eff = (duration_r == '0) ? 31'd1 : duration_r;
  assign per_eff = (period_r == '0) ? 16'd1 : period_r;
  assign is_vib  = (mode_r == MODE_VIB_IN) || (mode_r == MODE_VIB_OUT);
  assign is_osc  = is_vib || (mode_r == MODE_ELAS_IN) || (mode_r == MODE_ELAS_OUT) ||
                   (mode_r == MODE_ELAS_INOUT);

  assign en       = !skid_v_r;
  assign in_ready = en;

  // valid and done travel with the data
  assign done0 = !loop_en_r &&
                 (in_time_now[31] || (in_time_now > $signed({1'b0, duration_r})));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      done_r <= {done_r[NST-2:0], done0};
    end
  end

  // time wrap: |t| mod duration, one bit per stage
  always_comb begin
    a_nxt[0].neg = in_time_now[31];
    a_nxt[0].mag = in_time_now[31] ? 32'(-in_time_now) : 32'(in_time_now);
    a_nxt[0].rem = '0;
    if (in_time_now[31]) begin
      a_nxt[0].clamp = '0;
    end else if (in_time_now > $signed({1'b0, dur_eff})) begin
      a_nxt[0].clamp = dur_eff;
    end else begin
      a_nxt[0].clamp = in_time_now[30:0];
    end
  end

  for (genvar k = 1; k < A_N; k++) begin : g_wrap
    logic [31:0] sh;
    logic        ge;
    assign sh = {a_r[k-1].rem, a_r[k-1].mag[32-k]};
    assign ge = sh >= {1'b0, dur_eff};
    always_comb begin
      a_nxt[k] = a_r[k-1];
      a_nxt[k].rem = ge ? 31'(sh - {1'b0, dur_eff}) : sh[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < A_N; k++) a_r[k] <= a_nxt[k];
    end
  end

  // phase: u = tt * 2^16 / duration
  always_comb begin
    b_nxt[0].u = '0;
    if (!loop_en_r) begin
      b_nxt[0].rem = a_r[A_N-1].clamp;
    end else if (a_r[A_N-1].neg && (a_r[A_N-1].rem != '0)) begin
      b_nxt[0].rem = dur_eff - a_r[A_N-1].rem;
    end else begin
      b_nxt[0].rem = a_r[A_N-1].rem;
    end
  end

  for (genvar k = 1; k < B_N; k++) begin : g_phase
    logic [31:0] sh;
    logic        ge;
    if (k == 1) begin : g_first
      assign sh = {1'b0, b_r[k-1].rem};
    end else begin : g_rest
      assign sh = {b_r[k-1].rem, 1'b0};
    end
    assign ge = sh >= {1'b0, dur_eff};
    always_comb begin
      b_nxt[k].u   = {b_r[k-1].u[U_W-2:0], ge};
      b_nxt[k].rem = ge ? 31'(sh - {1'b0, dur_eff}) : sh[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < B_N; k++) b_r[k] <= b_nxt[k];
    end
  end

  // curve argument
  always_comb begin
    c_nxt.u  = b_r[B_N-1].u;
    c_nxt.hi = b_r[B_N-1].u[16] | b_r[B_N-1].u[15];
    unique case (mode_r)
      MODE_QUAD_OUT, MODE_ELAS_OUT, MODE_VIB_OUT: begin
        c_nxt.w = 17'h10000 - b_r[B_N-1].u;
      end
      MODE_QUAD_INOUT, MODE_ELAS_INOUT: begin
        if (c_nxt.hi) begin
          c_nxt.w = 17'(18'h20000 - {b_r[B_N-1].u, 1'b0});
        end else begin
          c_nxt.w = 17'({b_r[B_N-1].u, 1'b0});
        end
      end
      default: c_nxt.w = b_r[B_N-1].u;
    endcase
    c_nxt.n = 17'h10000 - c_nxt.w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  // oscillation turns: low 16 bits of n * 2^16 / period
  logic [33:0] wsq;
  assign wsq = c_r.w * c_r.w;

  always_comb begin
    d_nxt[0].side.u  = c_r.u;
    d_nxt[0].side.hi = c_r.hi;
    d_nxt[0].side.sq = wsq[32:16];
    d_nxt[0].n       = c_r.n;
    d_nxt[0].rem     = '0;
    d_nxt[0].q       = '0;
  end

  for (genvar k = 1; k < D_N; k++) begin : g_turn
    logic        nb;
    logic [16:0] sh;
    logic        ge;
    if (k <= U_W) begin : g_dig
      assign nb = d_r[k-1].n[U_W-k];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign sh = {d_r[k-1].rem, nb};
    assign ge = sh >= {1'b0, per_eff};
    always_comb begin
      d_nxt[k] = d_r[k-1];
      d_nxt[k].rem = ge ? 16'(sh - {1'b0, per_eff}) : sh[15:0];
      d_nxt[k].q   = {d_r[k-1].q[14:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < D_N; k++) d_r[k] <= d_nxt[k];
    end
  end

  // table indexes
  logic [15:0] phase;
  logic [15:0] offs;
  logic [19:0] m10;
  logic [19:0] mp;
  logic [19:0] fw;

  always_comb begin
    offs  = is_vib ? 16'h8000 : 16'h4000;
    phase = 16'h0000 - d_r[D_N-1].q - offs;
    m10   = {d_r[D_N-1].n, 3'b000} + {2'b00, d_r[D_N-1].n, 1'b0};
    mp    = m10 + 20'h0FFFF;
    fw    = {mp[19:16], 16'h0000} - m10;
    e1_nxt.side = d_r[D_N-1].side;
    e1_nxt.sidx = phase[15 -: SINE_TABLE_BITS];
    e1_nxt.fidx = fw[15 -: EXP_TABLE_BITS];
    e1_nxt.a    = mp[19:16];
  end

  // table reads
  always_comb begin
    e2_nxt.side = e1_r.side;
    e2_nxt.sinv = SIN_TAB[e1_r.sidx];
    e2_nxt.amp  = EXP_TAB[e1_r.fidx] >> e1_r.a;
  end

  always_comb begin
    e3_nxt.side = e2_r.side;
    e3_nxt.prod = $signed({1'b0, e2_r.amp}) * e2_r.sinv;
  end

  // curve shaping
  logic signed [35:0] neg_prod;
  logic signed [19:0] core;
  logic signed [20:0] inner;

  always_comb begin
    neg_prod = -e3_r.prod;
    core     = neg_prod[35:16];
    inner    = is_osc ? 21'(core) : 21'($signed({1'b0, e3_r.side.sq}));
    unique case (mode_r)
      MODE_QUAD_IN, MODE_ELAS_IN, MODE_VIB_IN, MODE_VIB_OUT: begin
        e4_scale_nxt = inner;
      end
      MODE_QUAD_OUT, MODE_ELAS_OUT: begin
        e4_scale_nxt = 21'sd65536 - inner;
      end
      MODE_QUAD_INOUT, MODE_ELAS_INOUT: begin
        if (e3_r.side.hi) begin
          e4_scale_nxt = 21'sd32768 + ((21'sd65536 - inner) >>> 1);
        end else begin
          e4_scale_nxt = inner >>> 1;
        end
      end
      default: e4_scale_nxt = 21'($signed({1'b0, e3_r.side.u}));
    endcase
  end

  // blend and saturate
  logic signed [32:0] diff;
  logic signed [53:0] rnd;
  logic signed [38:0] res;

  always_comb begin
    diff        = 33'(end_r) - 33'(start_r);
    f1_prod_nxt = e4_scale_r * diff;
  end

  always_comb begin
    rnd = f1_prod_r + 54'sd32768;
    res = 39'(rnd >>> 16) + 39'(start_r);
    if (res > 39'sd2147483647) begin
      f2_val_nxt = 32'sh7FFFFFFF;
    end else if (res < -39'sd2147483648) begin
      f2_val_nxt = 32'sh80000000;
    end else begin
      f2_val_nxt = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r       <= e1_nxt;
      e2_r       <= e2_nxt;
      e3_r       <= e3_nxt;
      e4_scale_r <= e4_scale_nxt;
      f1_prod_r  <= f1_prod_nxt;
      f2_val_r   <= f2_val_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!skid_v_r) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= vld_r[NST-1];
      end else if (vld_r[NST-1]) begin
        skid_v_r <= 1'b1;
      end
    end else if (out_ready) begin
      skid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      if (!out_valid_r || out_ready) begin
        out_val_r  <= f2_val_r;
        out_done_r <= done_r[NST-1];
      end else begin
        skid_val_r  <= f2_val_r;
        skid_done_r <= done_r[NST-1];
      end
    end else if (out_ready) begin
      out_val_r  <= skid_val_r;
      out_done_r <= skid_done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tween_value = out_val_r;
  assign out_done_flag   = out_done_r;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds a request while output register is empty");

  a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ready |=> skid_v_r && out_valid_r)
    else $error("stalled request dropped from skid stage");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_C-1] |-> b_r[B_N-1].u <= 17'h10000)
    else $error("phase exceeds one");

  a_arg_split: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_C] |-> ({1'b0, c_r.w} + {1'b0, c_r.n} == 18'h10000))
    else $error("curve argument and its complement disagree");
`endif

endmodule
`default_nettype wire

/* test/easing_curve_tween_generator_unit_tb.sv */
// ----------------------------------------------------------------------------
// easing_curve_tween_generator_unit_tb
// drives time samples through the tween unit under many register settings,
// predicts each interpolated value and done flag, and checks every response
// ----------------------------------------------------------------------------
module easing_curve_tween_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ectg_pkg::*;

  localparam longint UNIT = 65536;
  localparam int WATCH_LIMIT = 3000;
  localparam int SETTLE = 120;

  typedef struct {
    logic signed [31:0] val;
    logic               done;
  } tween_t;

  typedef struct {
    logic [3:0]         mode;
    logic               loop;
    logic [31:0]        dur;
    logic signed [31:0] sv;
    logic signed [31:0] ev;
    logic [31:0]        per;
    logic signed [31:0] tm;
    logic               known;
    logic signed [31:0] xv;
    logic               xd;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_time_now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_tween_value;
  logic out_done_flag;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  longint sine_lut [1024];
  longint pow2_lut [1024];

  logic [3:0]         cur_mode = 4'd0;
  logic               cur_loop = 1'b0;
  logic [30:0]        cur_dur = 31'd65536;
  logic signed [31:0] cur_start = 32'sd0;
  logic signed [31:0] cur_end = 32'sd65536;
  logic [15:0]        cur_per = 16'd19661;

  tween_t pending_q [$];
  row_t   rows [$];
  logic   row_known = 1'b0;
  tween_t row_result;

  int err_cnt = 0;
  int sent_cnt = 0;
  int got_cnt = 0;
  int idle_mode = 2;
  int hold_len = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  easing_curve_tween_generator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_time_now(in_time_now),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tween_value(out_tween_value), .out_done_flag(out_done_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint taylor_sin(longint x);
    longint x2, term, sum;
    x2 = (x * x) / ONE_Q30;
    term = x;
    sum = x;
    for (int k = 1; k <= 10; k++) begin
      term = -((term * x2) / ONE_Q30) / longint'((2 * k) * (2 * k + 1));
      sum += term;
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  task automatic fill_luts();
    longint x, s, y, term, sum;
    for (int i = 0; i <= 256; i++) begin
      x = (64'sd2 * PI_Q30 * i) / 1024;
      s = (taylor_sin(x) + 8192) >>> 14;
      sine_lut[i] = s;
      sine_lut[512 - i] = s;
      sine_lut[512 + i] = -s;
      if (i > 0) sine_lut[1024 - i] = -s;
    end
    for (int i = 0; i < 1024; i++) begin
      y = (LN2_Q30 * i) / 1024;
      term = ONE_Q30;
      sum = ONE_Q30;
      for (int k = 1; k <= 12; k++) term = (term * y) / ONE_Q30 / k;
      sum = ONE_Q30;
      term = ONE_Q30;
      for (int k = 1; k <= 12; k++) begin
        term = (term * y) / ONE_Q30 / k;
        sum += term;
      end
      pow2_lut[i] = (sum + 8192) >>> 14;
    end
  endtask

  function automatic longint swing(longint u, longint offs);
    longint p, n, q, ph, s, m, a, f, amp;
    p = (cur_per == 0) ? 1 : longint'(cur_per);
    n = UNIT - u;
    q = (n << 16) / p;
    ph = ((-q) - offs) & 64'hFFFF;
    s = sine_lut[ph >> 6];
    m = 10 * n;
    a = (m + 65535) >> 16;
    f = (a << 16) - m;
    amp = pow2_lut[f >> 6] >> a;
    return (-(amp * s)) >>> 16;
  endfunction

  function automatic longint curve_in(longint u, bit osc);
    return osc ? swing(u, 16384) : ((u * u) >> 16);
  endfunction

  function automatic longint curve_out(longint u, bit osc);
    return UNIT - curve_in(UNIT - u, osc);
  endfunction

  function automatic longint curve_inout(longint u, bit osc);
    if (u < 32768) return curve_in(2 * u, osc) >>> 1;
    return 32768 + (curve_out(2 * u - UNIT, osc) >>> 1);
  endfunction

  function automatic tween_t tween_of(longint tm);
    tween_t r;
    longint d, tt, u, sc, res;
    d = (cur_dur == 0) ? 1 : longint'(cur_dur);
    r.done = 1'b0;
    if (cur_loop) begin
      tt = tm % d;
      if (tt < 0) tt += d;
    end else begin
      r.done = (tm < 0) || (tm > longint'(cur_dur));
      tt = (tm < 0) ? 0 : ((tm > d) ? d : tm);
    end
    u = (tt << 16) / d;
    case (cur_mode)
      MODE_QUAD_IN:    sc = curve_in(u, 0);
      MODE_QUAD_OUT:   sc = curve_out(u, 0);
      MODE_QUAD_INOUT: sc = curve_inout(u, 0);
      MODE_ELAS_IN:    sc = curve_in(u, 1);
      MODE_ELAS_OUT:   sc = curve_out(u, 1);
      MODE_ELAS_INOUT: sc = curve_inout(u, 1);
      MODE_VIB_IN:     sc = swing(u, 32768);
      MODE_VIB_OUT:    sc = swing(UNIT - u, 32768);
      default:         sc = u;
    endcase
    res = longint'(cur_start)
        + ((sc * (longint'(cur_end) - longint'(cur_start)) + 32768) >>> 16);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.val = res[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (response %0d)", what, got, want, got_cnt);
    err_cnt++;
  endtask

  // register mirror, request scoreboard and response check
  always @(posedge clk) begin
    tween_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CURVE_MODE:  cur_mode <= cfg_data[3:0];
          CFG_LOOP_ENABLE: cur_loop <= cfg_data[0];
          CFG_DURATION:    cur_dur <= cfg_data[30:0];
          CFG_START_VALUE: cur_start <= cfg_data;
          CFG_END_VALUE:   cur_end <= cfg_data;
          CFG_OSC_PERIOD:  cur_per <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pending_q.push_back(row_known ? row_result : tween_of(longint'(in_time_now)));
        sent_cnt++;
      end
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected response", out_tween_value, 0);
        end else begin
          want = pending_q.pop_front();
          if (out_tween_value !== want.val)
            report_mismatch("tween_value", out_tween_value, want.val);
          if (out_done_flag !== want.done)
            report_mismatch("done_flag", out_done_flag, want.done);
        end
        got_cnt++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("timeout with %0d responses outstanding", pending_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // response side
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_ready <= 1'b0;
      hold_len = hold_len - 1;
    end else if (idle_mode == 0) begin
      out_ready <= ($urandom_range(0, 99) >= 59);
    end else if (idle_mode == 1) begin
      out_ready <= ($urandom_range(0, 99) >= 34);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setting(logic [3:0] mode, logic loop, logic [31:0] dur,
                              logic [31:0] sv, logic [31:0] ev, logic [31:0] per);
    write_reg(CFG_CURVE_MODE, {28'd0, mode});
    write_reg(CFG_LOOP_ENABLE, {31'd0, loop});
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_START_VALUE, sv);
    write_reg(CFG_END_VALUE, ev);
    write_reg(CFG_OSC_PERIOD, per);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_time(logic signed [31:0] tm);
    int pct;
    pct = (idle_mode == 0) ? 34 : ((idle_mode == 1) ? 59 : 0);
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_time_now <= tm;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_row(logic [3:0] mode, logic loop, logic [31:0] dur, logic [31:0] sv,
                         logic [31:0] ev, logic [31:0] per, logic [31:0] tm,
                         logic known, logic [31:0] xv, logic xd);
    row_t r;
    r = '{mode, loop, dur, sv, ev, per, tm, known, xv, xd};
    rows.push_back(r);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 1 << 20) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] d, per, tm;
    longint span;
    fill_luts();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults, extremes, all curves and the odd register values
    add_row(MODE_LINEAR, 0, 65536, 0, 65536, 19661, 0, 1, 0, 0);
    add_row(MODE_LINEAR, 0, 65536, 0, 65536, 19661, 65536, 1, 65536, 0);
    add_row(MODE_LINEAR, 0, 65536, 0, 65536, 19661, 32'hFFFF_FFFF, 1, 0, 1);
    add_row(MODE_LINEAR, 0, 65536, 0, 65536, 19661, 32'h7FFF_FFFF, 1, 65536, 1);
    add_row(MODE_LINEAR, 0, 65536, 0, 65536, 19661, 32'h8000_0000, 1, 0, 1);
    for (int m = 1; m <= 8; m++) begin
      add_row(4'(m), 0, 65536, 32'hFFFF_0000, 32'h0003_0000, 19661, 21000, 0, 0, 0);
      add_row(4'(m), 1, 131072, 0, 65536, 13107, 32'hFFFF_1234, 0, 0, 0);
    end
    add_row(4'd9, 0, 65536, 0, 65536, 19661, 16384, 1, 16384, 0);
    add_row(4'd15, 0, 65536, 0, 65536, 19661, 16384, 1, 16384, 0);
    add_row(MODE_LINEAR, 0, 0, 0, 65536, 19661, 1, 1, 65536, 1);
    add_row(MODE_ELAS_IN, 0, 65536, 0, 65536, 0, 40000, 0, 0, 0);
    add_row(MODE_LINEAR, 1, 65536, 0, 65536, 19661, 32'hFFFF_C000, 1, 49152, 0);
    add_row(MODE_ELAS_OUT, 0, 65536, 32'h7FFF_FFFF, 32'h8000_0000, 65535, 9000, 0, 0, 0);
    add_row(MODE_QUAD_OUT, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
            32'hFFFF_FFFF, 0, 0, 0);

    idle_mode = 2;
    foreach (rows[i]) begin
      load_setting(rows[i].mode, rows[i].loop, rows[i].dur, rows[i].sv, rows[i].ev,
                   rows[i].per);
      row_known = rows[i].known;
      row_result.val = rows[i].xv;
      row_result.done = rows[i].xd;
      send_time(rows[i].tm);
      in_valid <= 1'b0;
      @(posedge clk);
      row_known = 1'b0;
      drain();
    end

    for (int blk = 0; blk < 25; blk++) begin
      idle_mode = (blk < 8) ? 0 : ((blk < 16) ? 1 : 2);
      case ($urandom_range(0, 9))
        0: d = 1;
        1: d = 32'h7FFF_FFFF;
        2: d = 0;
        3: d = $urandom;
        default: d = $urandom_range(1, 1 << 20);
      endcase
      case ($urandom_range(0, 5))
        0: per = 1;
        1: per = 65535;
        2: per = 0;
        default: per = $urandom;
      endcase
      load_setting(($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)),
                   $urandom_range(0, 1), d, pick_value(), pick_value(), per);
      if (blk == 20) hold_len = 400;
      span = (cur_dur == 0) ? 1 : longint'(cur_dur);
      for (int k = 0; k < 50; k++) begin
        if ($urandom_range(0, 9) < 7)
          tm = 32'($urandom_range(0, 32'(span + span / 2)) - span / 4);
        else
          tm = $urandom;
        send_time(tm);
      end
      drain();
    end

    $display("checked %0d of %0d time samples over 25 random register settings",
             got_cnt, sent_cnt);
    $display("covered all nine curves, looping and clamping, and a long output stall");
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
